FILE: design/aup_pkg.sv
// types, constants and the divider step shared by the alpha unpremultiply pipeline
// no dependencies

package aup_pkg;

  localparam int PIX_W           = 8;
  localparam int NUM_CH          = 3;
  localparam int STEPS_PER_STAGE = 2;
  localparam int DIV_STAGES      = PIX_W / STEPS_PER_STAGE;
  localparam int DATA_W          = 4 * PIX_W;

  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  localparam logic [PIX_W-1:0] PIX_MAX = '1;

  // partial remainder and dividend bits, quotient bits shift in at the bottom
  typedef struct packed {
    logic [PIX_W-1:0] rem;
    logic [PIX_W-1:0] shf;
  } chan_t;

  typedef struct packed {
    logic [PIX_W-1:0]  alpha;
    logic              zero;
    logic [NUM_CH-1:0] sat;
    chan_t [NUM_CH-1:0] ch;
  } pix_t;

  // one restoring division step
  function automatic chan_t div_step(chan_t c, logic [PIX_W-1:0] a);
    logic [PIX_W:0]   t;
    logic [PIX_W+1:0] d;
    chan_t            r;
    t = {c.rem, c.shf[PIX_W-1]};
    d = {1'b0, t} - {2'b00, a};
    if (!d[PIX_W+1]) begin
      r.rem = d[PIX_W-1:0];
      r.shf = {c.shf[PIX_W-2:0], 1'b1};
    end else begin
      r.rem = t[PIX_W-1:0];
      r.shf = {c.shf[PIX_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

FILE: design/aup_prep.sv
// input stage: unpacks the pixel, forms channel*255 and the saturation flags
// depends on aup_pkg

module aup_prep
  import aup_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DATA_W-1:0] in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output pix_t              out_pix
);

  logic valid_r, valid_nxt;
  pix_t pix_r, pix_nxt;

  logic [PIX_W-1:0]   a;
  logic [PIX_W-1:0]   c [NUM_CH];
  logic [2*PIX_W-1:0] num [NUM_CH];

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    a = in_data[PIX_W-1:0];
    for (int i = 0; i < NUM_CH; i++) begin
      c[i] = in_data[(i+1)*PIX_W +: PIX_W];
    end
    pix_nxt.alpha = a;
    pix_nxt.zero  = (a == '0);
    for (int i = 0; i < NUM_CH; i++) begin
      // c*255 as c*256 - c
      num[i]            = {c[i], {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, c[i]};
      pix_nxt.sat[i]    = (c[i] > a);
      pix_nxt.ch[i].rem = num[i][2*PIX_W-1:PIX_W];
      pix_nxt.ch[i].shf = num[i][PIX_W-1:0];
    end
    valid_nxt = in_ready ? in_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (in_valid && in_ready) begin
      pix_r <= pix_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_pix   = pix_r;

endmodule

FILE: design/aup_div_stage.sv
// one divider stage: STEPS_PER_STAGE restoring steps on all three colour channels
// depends on aup_pkg

module aup_div_stage
  import aup_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  pix_t in_pix,
  output logic out_valid,
  input  logic out_ready,
  output pix_t out_pix
);

  logic valid_r, valid_nxt;
  pix_t pix_r, pix_nxt;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    pix_nxt = in_pix;
    for (int i = 0; i < NUM_CH; i++) begin
      for (int s = 0; s < STEPS_PER_STAGE; s++) begin
        pix_nxt.ch[i] = div_step(pix_nxt.ch[i], in_pix.alpha);
      end
    end
    valid_nxt = in_ready ? in_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (in_valid && in_ready) begin
      pix_r <= pix_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_pix   = pix_r;

endmodule

FILE: design/aup_out.sv
// output stage: transparent and saturated cases, packs the result word
// depends on aup_pkg

module aup_out
  import aup_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pix_t              in_pix,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_data
);

  logic              valid_r, valid_nxt;
  logic [DATA_W-1:0] data_r, data_nxt;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    data_nxt = '0;
    if (!in_pix.zero) begin
      for (int i = 0; i < NUM_CH; i++) begin
        data_nxt[i*PIX_W +: PIX_W] = in_pix.sat[i] ? PIX_MAX : in_pix.ch[i].shf;
      end
      data_nxt[NUM_CH*PIX_W +: PIX_W] = in_pix.alpha;
    end
    valid_nxt = in_ready ? in_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

FILE: design/alpha_unpremultiply.sv
// top level of the alpha unpremultiply pipeline: prep, divider stages, output
// depends on aup_pkg, aup_prep, aup_div_stage, aup_out
//
//   channel  direction  tdata fields (low bit up)
//   in_      slave      alpha, red, green, blue
//   out_     master     red, green, blue, alpha
//
// one pixel per cycle while out_tready is high: one prep stage, four divider
// stages of two restoring steps each, one output register
// rst_n is synchronous and clears only the stage valid bits
// each stage takes a transfer when it is empty or its successor moves, so
// bubbles close up and a stall on out_tready loses and repeats nothing

module alpha_unpremultiply
  import aup_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,   // alpha, red, green, blue
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata   // red, green, blue, alpha
);

  logic valid [DIV_STAGES+1];
  logic ready [DIV_STAGES+1];
  pix_t pix   [DIV_STAGES+1];

  aup_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_data   (in_tdata),
    .out_valid (valid[0]),
    .out_ready (ready[0]),
    .out_pix   (pix[0])
  );

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    aup_div_stage u_div (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (valid[k]),
      .in_ready  (ready[k]),
      .in_pix    (pix[k]),
      .out_valid (valid[k+1]),
      .out_ready (ready[k+1]),
      .out_pix   (pix[k+1])
    );
  end

  aup_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (valid[DIV_STAGES]),
    .in_ready  (ready[DIV_STAGES]),
    .in_pix    (pix[DIV_STAGES]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule
